// ===== rtl/core/srcs_pkg.sv =====
// Shared opcodes, function codes and result type of the scalar integer core.
package srcs_pkg;

  // Input word layout
  localparam int unsigned INSTR_W    = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IN_TDATA_W = 40;

  // tuser selector
  localparam logic FUNC_EXEC   = 1'b0;
  localparam logic FUNC_STATUS = 1'b1;

  // Status command bits
  localparam int unsigned ST_CLR_HALT  = 0;
  localparam int unsigned ST_SET_HALT  = 1;
  localparam int unsigned ST_CLR_BROKE = 2;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function field
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_BREAK = 6'h0D;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;

  // REGIMM rt field
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [4:0]  LINK_REG   = 5'd31;
  localparam logic [31:0] STORE_BASE = 32'h0400_0000;

  // Per-word execute result, excluding the PC
  typedef struct packed {
    logic        store_valid;
    logic [31:0] store_address;
    logic [31:0] store_data;
    logic        write_valid;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic        is_halted;
    logic        is_broken;
    logic        unknown_op;
  } srcs_res_t;

endpackage

// ===== rtl/core/srcs_exec.sv =====
// Decode, ALU, branch resolution and flag update for one word.
module srcs_exec
  import srcs_pkg::*;
#(
  parameter int unsigned PC_BITS = 12
) (
  input  logic                func_i,
  input  logic [INSTR_W-1:0]  instr_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [31:0]         rs_val_i,
  input  logic [31:0]         rt_val_i,
  input  logic [PC_BITS-1:0]  pc_i,
  input  logic [PC_BITS-1:0]  next_pc_i,
  input  logic                halted_i,
  input  logic                broke_i,
  output srcs_res_t           res_o,
  output logic [PC_BITS-1:0]  pc_o,
  output logic [PC_BITS-1:0]  next_pc_o
);

  logic [5:0]         op;
  logic [5:0]         fn;
  logic [4:0]         rt;
  logic [4:0]         rd;
  logic [4:0]         sa;
  logic [15:0]        imm;
  logic [31:0]        imm_sx;
  logic [31:0]        imm_zx;
  logic [PC_BITS-1:0] pc_p4;
  logic [PC_BITS-1:0] btarget;
  logic [PC_BITS-1:0] jtarget;
  logic [PC_BITS-1:0] rtarget;
  logic [31:0]        link;
  logic               a_neg;
  logic               a_zero;

  logic               wv;
  logic [4:0]         widx;
  logic [31:0]        wval;
  logic               sv;
  logic               unk;
  logic               take;
  logic [PC_BITS-1:0] target;
  logic               halted_d;
  logic               broke_d;

  assign op      = instr_i[31:26];
  assign fn      = instr_i[5:0];
  assign rt      = instr_i[20:16];
  assign rd      = instr_i[15:11];
  assign sa      = instr_i[10:6];
  assign imm     = instr_i[15:0];
  assign imm_sx  = {{16{imm[15]}}, imm};
  assign imm_zx  = {16'h0000, imm};
  assign pc_p4   = pc_i + PC_BITS'(4);
  assign btarget = pc_p4 + {imm_sx[PC_BITS-3:0], 2'b00};
  assign jtarget = {instr_i[PC_BITS-3:0], 2'b00};
  assign rtarget = {rs_val_i[PC_BITS-1:2], 2'b00};
  assign link    = {{(32-PC_BITS){1'b0}}, pc_i + PC_BITS'(8)};
  assign a_neg   = rs_val_i[31];
  assign a_zero  = (rs_val_i == 32'h0);

  always_comb begin
    wv       = 1'b0;
    widx     = rd;
    wval     = 32'h0;
    sv       = 1'b0;
    unk      = 1'b0;
    take     = 1'b0;
    target   = btarget;
    halted_d = halted_i;
    broke_d  = broke_i;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin wv = 1'b1; wval = rt_val_i << sa; end
          FN_SRL:  begin wv = 1'b1; wval = rt_val_i >> sa; end
          FN_SRA:  begin wv = 1'b1; wval = 32'($signed(rt_val_i) >>> sa); end
          FN_SLLV: begin wv = 1'b1; wval = rt_val_i << rs_val_i[4:0]; end
          FN_SRLV: begin wv = 1'b1; wval = rt_val_i >> rs_val_i[4:0]; end
          FN_SRAV: begin
            wv   = 1'b1;
            wval = 32'($signed(rt_val_i) >>> rs_val_i[4:0]);
          end
          FN_JR: begin
            take   = 1'b1;
            target = rtarget;
          end
          FN_JALR: begin
            take   = 1'b1;
            target = rtarget;
            wv     = 1'b1;
            wval   = link;
          end
          FN_BREAK: begin
            halted_d = 1'b1;
            broke_d  = 1'b1;
          end
          FN_ADD, FN_ADDU: begin wv = 1'b1; wval = rs_val_i + rt_val_i; end
          FN_SUB, FN_SUBU: begin wv = 1'b1; wval = rs_val_i - rt_val_i; end
          FN_AND:  begin wv = 1'b1; wval = rs_val_i & rt_val_i; end
          FN_OR:   begin wv = 1'b1; wval = rs_val_i | rt_val_i; end
          FN_XOR:  begin wv = 1'b1; wval = rs_val_i ^ rt_val_i; end
          FN_NOR:  begin wv = 1'b1; wval = ~(rs_val_i | rt_val_i); end
          default: unk = 1'b1;
        endcase
      end
      OP_REGIMM: begin
        case (rt)
          RI_BLTZ: take = a_neg;
          RI_BGEZ: take = ~a_neg;
          RI_BLTZAL: begin
            take = a_neg;
            wv   = 1'b1;
            widx = LINK_REG;
            wval = link;
          end
          RI_BGEZAL: begin
            take = ~a_neg;
            wv   = 1'b1;
            widx = LINK_REG;
            wval = link;
          end
          default: unk = 1'b1;
        endcase
      end
      OP_J: begin
        take   = 1'b1;
        target = jtarget;
      end
      OP_JAL: begin
        take   = 1'b1;
        target = jtarget;
        wv     = 1'b1;
        widx   = LINK_REG;
        wval   = link;
      end
      OP_BEQ:  take = (rs_val_i == rt_val_i);
      OP_BNE:  take = (rs_val_i != rt_val_i);
      OP_BLEZ: take = a_neg | a_zero;
      OP_BGTZ: take = ~a_neg & ~a_zero;
      OP_ADDI, OP_ADDIU: begin wv = 1'b1; widx = rt; wval = rs_val_i + imm_sx; end
      OP_ANDI: begin wv = 1'b1; widx = rt; wval = rs_val_i & imm_zx; end
      OP_ORI:  begin wv = 1'b1; widx = rt; wval = rs_val_i | imm_zx; end
      OP_XORI: begin wv = 1'b1; widx = rt; wval = rs_val_i ^ imm_zx; end
      OP_LUI:  begin wv = 1'b1; widx = rt; wval = {imm, 16'h0000}; end
      OP_SW:   sv = 1'b1;
      default: unk = 1'b1;
    endcase
  end

  always_comb begin
    res_o = '0;
    pc_o      = pc_i;
    next_pc_o = next_pc_i;
    if (func_i == FUNC_STATUS) begin
      res_o.is_halted = status_i[ST_SET_HALT] ? 1'b1 :
                        (status_i[ST_CLR_HALT] ? 1'b0 : halted_i);
      res_o.is_broken = status_i[ST_CLR_BROKE] ? 1'b0 : broke_i;
    end else begin
      // r0 writes are dropped and report as no write
      if (wv && (widx != 5'd0)) begin
        res_o.write_valid = 1'b1;
        res_o.write_index = widx;
        res_o.write_value = wval;
      end
      if (sv) begin
        res_o.store_valid   = 1'b1;
        res_o.store_address = STORE_BASE | (rs_val_i + imm_sx);
        res_o.store_data    = rt_val_i;
      end
      res_o.unknown_op = unk;
      res_o.is_halted  = halted_d;
      res_o.is_broken  = broke_d;
      // taken: run the delay slot next, then go to target
      if (take) begin
        pc_o      = pc_p4;
        next_pc_o = target;
      end else begin
        pc_o      = next_pc_i;
        next_pc_o = next_pc_i + PC_BITS'(4);
      end
    end
  end

endmodule

// ===== rtl/core/scalar_risc_core_step.sv =====
// Top level of the scalar integer core: input register, register file, execute, result register.
//
// Scalar MIPS-I style integer core that executes one instruction word (or one status
// command) per input word and returns one result word for each. Throughput is one word
// per clock while m_axis does not stall: a word is accepted while the previous one
// executes, and the result register lets a new word enter while an earlier result still
// waits. Each word executes from the input register, and its result is captured in the
// result register that drives m_axis. At acceptance the rs and rt fields are looked up in
// the 32 x 32 register file (registered read); if the word executing in that same cycle
// writes one of those registers, its value is bypassed, so back-to-back dependent words
// see correct operands. Execute (decode, ALU, branch and PC update) is a single stage, and
// the register file, PC pair and halt/break flags are updated as the result is registered.
// Registers read as zero after reset through a per-entry valid bit; no clearing pass is
// needed. Branches and jumps have one delay slot; fetch_address is the PC to fetch next.
// An unknown opcode raises unknown_op, writes nothing and still advances the PC.
module scalar_risc_core_step
  import srcs_pkg::*;
#(
  parameter int unsigned PC_BITS = 12,
  localparam int unsigned OUT_BITS    = PC_BITS + 106,
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] instruction, [34:32] status_bits, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // from bit 0 up: fetch_address, store_valid, store_address, store_data,
  // write_valid, write_index, write_value, is_halted, is_broken, unknown_op, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Input register
  logic                ex_vld_q;
  logic                ex_func_q;
  logic [INSTR_W-1:0]  ex_instr_q;
  logic [STATUS_W-1:0] ex_status_q;

  // Register file and operand capture
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] mem_a_q, mem_b_q;
  logic        vld_a_q, vld_b_q;
  logic        byp_a_q, byp_b_q;
  logic [31:0] byp_val_q;
  logic [31:0] rs_val, rt_val;

  // Architectural state
  logic [PC_BITS-1:0] pc_q, pc_d;
  logic [PC_BITS-1:0] npc_q, npc_d;
  logic               halted_q, broke_q;

  // Result register
  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  srcs_res_t   res;
  logic        in_fire, ex_fire, wr_en;
  logic [4:0]  rs_in, rt_in;

  assign ex_fire       = ex_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~ex_vld_q | ex_fire;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign rs_in         = s_axis_tdata[25:21];
  assign rt_in         = s_axis_tdata[20:16];
  assign wr_en         = ex_fire & res.write_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      ex_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ex_func_q   <= s_axis_tuser;
      ex_instr_q  <= s_axis_tdata[INSTR_W-1:0];
      ex_status_q <= s_axis_tdata[INSTR_W+STATUS_W-1:INSTR_W];
    end
  end

  // Register file storage: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rf_mem[res.write_index] <= res.write_value;
    end
    if (in_fire) begin
      mem_a_q <= rf_mem[rs_in];
      mem_b_q <= rf_mem[rt_in];
    end
  end

  // Written-since-reset bits; r0 is never written so it stays zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (wr_en) begin
      rf_vld_q[res.write_index] <= 1'b1;
    end
  end

  // Operand flags and bypass of the word retiring in the same cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      vld_a_q   <= rf_vld_q[rs_in];
      vld_b_q   <= rf_vld_q[rt_in];
      byp_a_q   <= wr_en & (res.write_index == rs_in);
      byp_b_q   <= wr_en & (res.write_index == rt_in);
      byp_val_q <= res.write_value;
    end
  end

  assign rs_val = byp_a_q ? byp_val_q : (vld_a_q ? mem_a_q : 32'h0);
  assign rt_val = byp_b_q ? byp_val_q : (vld_b_q ? mem_b_q : 32'h0);

  srcs_exec #(
    .PC_BITS(PC_BITS)
  ) u_exec (
    .func_i    (ex_func_q),
    .instr_i   (ex_instr_q),
    .status_i  (ex_status_q),
    .rs_val_i  (rs_val),
    .rt_val_i  (rt_val),
    .pc_i      (pc_q),
    .next_pc_i (npc_q),
    .halted_i  (halted_q),
    .broke_i   (broke_q),
    .res_o     (res),
    .pc_o      (pc_d),
    .next_pc_o (npc_d)
  );

  // PC pair and flags commit with the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      npc_q    <= PC_BITS'(4);
      halted_q <= 1'b1;
      broke_q  <= 1'b0;
    end else if (ex_fire) begin
      pc_q     <= pc_d;
      npc_q    <= npc_d;
      halted_q <= res.is_halted;
      broke_q  <= res.is_broken;
    end
  end

  always_comb begin
    out_data_d = '0;
    out_data_d[OUT_BITS-1:0] = {res.unknown_op, res.is_broken, res.is_halted,
                                res.write_value, res.write_index, res.write_valid,
                                res.store_data, res.store_address, res.store_valid,
                                pc_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ex_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/srcs_checker.sv =====
// Port-level checks on the scalar integer core, bound to the top level.
module srcs_checker
  import srcs_pkg::*;
#(
  parameter int unsigned PC_BITS = 12,
  localparam int unsigned OUT_BITS    = PC_BITS + 106,
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SV_B   = PC_BITS;
  localparam int unsigned SA_LO  = PC_BITS + 1;
  localparam int unsigned SD_LO  = PC_BITS + 33;
  localparam int unsigned WV_B   = PC_BITS + 65;
  localparam int unsigned WI_LO  = PC_BITS + 66;
  localparam int unsigned WD_LO  = PC_BITS + 71;
  localparam int unsigned UNK_B  = PC_BITS + 105;

  logic        sv, wv, unk;
  logic [31:0] saddr, sdata, wval;
  logic [4:0]  widx;

  assign sv    = m_axis_tdata[SV_B];
  assign saddr = m_axis_tdata[SA_LO +: 32];
  assign sdata = m_axis_tdata[SD_LO +: 32];
  assign wv    = m_axis_tdata[WV_B];
  assign widx  = m_axis_tdata[WI_LO +: 5];
  assign wval  = m_axis_tdata[WD_LO +: 32];
  assign unk   = m_axis_tdata[UNK_B];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // r0 is never reported as written; no write means zero fields
  a_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (wv && widx != 5'd0) || (!wv && widx == 5'd0 && wval == 32'h0))
    else $error("inconsistent write fields");

  // store carries the base bit, no store means zero fields
  a_store_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sv && saddr[26]) || (!sv && saddr == 32'h0 && sdata == 32'h0))
    else $error("inconsistent store fields");

  // unknown opcode has no side effect
  a_unknown_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && unk |-> !wv && !sv)
    else $error("unknown opcode wrote or stored");

endmodule

bind scalar_risc_core_step srcs_checker #(.PC_BITS(PC_BITS)) u_srcs_checker (.*);
